// ----- hw/rtl/sss_pkg.sv -----
// Shared widths, field layout and controller state type for the selective scan.
package sss_pkg;

	localparam int CH_W     = 6;
	localparam int IDX_W    = 4;
	localparam int COEF_W   = 16;
	localparam int H_W      = 32;
	localparam int SUM_W    = 48;
	localparam int Y_W      = 40;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 48;

	// One-hot controller states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PROD = 5'b00010,
		ST_HNEW = 5'b00100,
		ST_TERM = 5'b01000,
		ST_ACC  = 5'b10000
	} sss_state_t;

endpackage

// ----- hw/rtl/selective_state_space_scan.sv -----
// Selective state-space scan: hidden-state memory, recurrence update and output accumulation.
// Items are taken one at a time: a new item is accepted only once the controller is back in
// idle after the read, multiply, round and write-back pass through the hidden-state memory
// and the output accumulation; a held result stalls only the next emit.
// Reset: arst_n clears the controller, the output sum and the output valid; the
// hidden-state memory is not cleared and holds garbage until each entry is written.
module selective_state_space_scan #(
	parameter int CHANNELS   = 64,
	parameter int STATE_SIZE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// channel[5:0], state_index[9:6], decay[25:10], input_gain[41:26],
	// output_gain[57:42], sample[73:58], zero fill[79:74]
	input  logic [sss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// first_step
	input  logic                           s_axis_tuser,
	// last_state
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_channel[5:0], out_value[45:6], zero fill[47:46]
	output logic [sss_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import sss_pkg::*;

	localparam int DEPTH = CHANNELS * STATE_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic signed [49:0] H_MAX_W   = 50'sd2147483647;
	localparam logic signed [49:0] H_MIN_W   = -H_MAX_W - 50'sd1;
	localparam logic signed [49:0] SUM_MAX_W = 50'sd140737488355327;
	localparam logic signed [49:0] SUM_MIN_W = -SUM_MAX_W - 50'sd1;
	localparam logic signed [47:0] Y_MAX_W   = 48'sd549755813887;
	localparam logic signed [47:0] Y_MIN_W   = -Y_MAX_W - 48'sd1;

	sss_state_t state_q;

	// Input field views
	logic [CH_W-1:0]          in_channel;
	logic [IDX_W-1:0]         in_index;
	logic [COEF_W-1:0]        in_decay;
	logic signed [COEF_W-1:0] in_b;
	logic signed [COEF_W-1:0] in_c;
	logic signed [COEF_W-1:0] in_x;
	logic                     in_range;
	logic [31:0]              addr_full;
	logic                     accept;

	// Item registers
	logic [CH_W-1:0]          channel_q;
	logic                     index_zero_q;
	logic [COEF_W-1:0]        decay_q;
	logic signed [COEF_W-1:0] c_q;
	logic                     first_q;
	logic                     last_q;
	logic                     in_range_q;
	logic [AW-1:0]            addr_q;
	logic signed [31:0]       bx_q;

	// Memory and datapath registers
	logic signed [H_W-1:0]    mem [DEPTH];
	logic signed [H_W-1:0]    rd_q;
	logic signed [48:0]       ah_s2;
	logic signed [H_W-1:0]    h_s3;
	logic signed [47:0]       ch_s4;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;

	// Combinational datapath
	logic signed [H_W-1:0]    prev;
	logic signed [16:0]       decay_ext;
	logic signed [48:0]       ah;
	logic signed [49:0]       wide;
	logic signed [49:0]       wide_sh;
	logic signed [H_W-1:0]    h_new;
	logic signed [49:0]       term;
	logic signed [49:0]       acc;
	logic signed [SUM_W-1:0]  sum_new;
	logic signed [47:0]       sum_ext;
	logic [Y_W-1:0]           y;
	logic                     out_free;
	logic                     acc_go;

	assign in_channel = s_axis_tdata[5:0];
	assign in_index   = s_axis_tdata[9:6];
	assign in_decay   = s_axis_tdata[25:10];
	assign in_b       = $signed(s_axis_tdata[41:26]);
	assign in_c       = $signed(s_axis_tdata[57:42]);
	assign in_x       = $signed(s_axis_tdata[73:58]);

	// Decode the hidden-state address
	assign in_range  = (32'(in_channel) < 32'(CHANNELS)) && (32'(in_index) < 32'(STATE_SIZE));
	assign addr_full = 32'(in_channel) * 32'(STATE_SIZE) + 32'(in_index);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign out_free = !out_valid_q || m_axis_tready;
	assign acc_go   = (state_q == ST_ACC) && (!last_q || out_free);

	// Capture the item and form b*x
	always_ff @(posedge clk) begin
		if (accept) begin
			channel_q    <= in_channel;
			index_zero_q <= (in_index == '0);
			decay_q      <= in_decay;
			c_q          <= in_c;
			first_q      <= s_axis_tuser;
			last_q       <= s_axis_tlast;
			in_range_q   <= in_range;
			addr_q       <= addr_full[AW-1:0];
			bx_q         <= 32'(in_b) * 32'(in_x);
		end
	end

	// Hidden-state memory: read on accept, write back after rounding
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			rd_q <= mem[addr_full[AW-1:0]];
		end
		if (state_q == ST_HNEW && in_range_q) begin
			mem[addr_q] <= h_new;
		end
	end

	// Decay times previous state
	assign prev      = (first_q || !in_range_q) ? '0 : rd_q;
	assign decay_ext = $signed({1'b0, decay_q});
	assign ah        = 49'(decay_ext) * 49'(prev);

	// Round to Q.14 and saturate the new hidden state
	assign wide    = 50'(ah_s2) + (50'(bx_q) <<< 1) + 50'sd16384;
	assign wide_sh = wide >>> 15;
	always_comb begin
		if (wide_sh > H_MAX_W) begin
			h_new = H_MAX_W[31:0];
		end else if (wide_sh < H_MIN_W) begin
			h_new = H_MIN_W[31:0];
		end else begin
			h_new = wide_sh[31:0];
		end
	end

	// Round the term and accumulate with saturation
	assign term = (50'(ch_s4) + 50'sd8192) >>> 14;
	assign acc  = (index_zero_q ? 50'sd0 : 50'(sum_q)) + term;
	always_comb begin
		if (acc > SUM_MAX_W) begin
			sum_new = SUM_MAX_W[47:0];
		end else if (acc < SUM_MIN_W) begin
			sum_new = SUM_MIN_W[47:0];
		end else begin
			sum_new = acc[47:0];
		end
	end

	// Clamp the emitted sum to 40 bits
	assign sum_ext = sum_new;
	always_comb begin
		if (sum_ext > Y_MAX_W) begin
			y = Y_MAX_W[39:0];
		end else if (sum_ext < Y_MIN_W) begin
			y = Y_MIN_W[39:0];
		end else begin
			y = sum_ext[39:0];
		end
	end

	// Pipeline registers of the arithmetic pass
	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			ah_s2 <= ah;
		end
		if (state_q == ST_HNEW) begin
			h_s3 <= h_new;
		end
		if (state_q == ST_TERM) begin
			ch_s4 <= 48'(c_q) * 48'(h_s3);
		end
	end

	// Output transaction data
	always_ff @(posedge clk) begin
		if (acc_go && last_q) begin
			out_data_q <= {2'b00, y, channel_q};
		end
	end

	// Controller, running sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_HNEW;
				ST_HNEW: state_q <= ST_TERM;
				ST_TERM: state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							sum_q       <= '0;
							out_valid_q <= 1'b1;
						end else begin
							sum_q <= sum_new;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the selective state-space scan: stream driver, predictor, checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sss_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	// One input transaction; the low 74 bits line up with s_axis_tdata
	typedef struct packed {
		logic              last_state;
		logic              first_step;
		logic [COEF_W-1:0] sample;
		logic [COEF_W-1:0] output_gain;
		logic [COEF_W-1:0] input_gain;
		logic [COEF_W-1:0] decay;
		logic [IDX_W-1:0]  state_index;
		logic [CH_W-1:0]   channel;
	} scan_item_t;

	// Predicts the emitted channel sums and checks them in order
	class scan_scoreboard;
		localparam longint H_HI = 64'sd2147483647;
		localparam longint H_LO = -64'sd2147483648;
		localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
		localparam longint SUM_LO = -64'sh8000_0000_0000;
		localparam longint Y_HI = 64'sh7F_FFFF_FFFF;
		localparam longint Y_LO = -64'sh80_0000_0000;

		logic signed [H_W-1:0] hidden [1024];
		longint                run_sum;
		logic [45:0]           sums_due [$];
		int                    errors;
		int                    sums_seen;

		function new();
			run_sum = 0;
			errors = 0;
			sums_seen = 0;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int pending();
			return sums_due.size();
		endfunction

		// Advance the recurrence and the running sum for one accepted item
		function void note_input(scan_item_t it);
			logic [CH_W+IDX_W-1:0] addr;
			longint prev;
			longint wide;
			longint h;
			longint term;
			longint y;
			addr = {it.channel, it.state_index};
			prev = it.first_step ? 64'sd0 : longint'(hidden[addr]);
			wide = longint'(it.decay) * prev
				+ 64'sd2 * longint'($signed(it.input_gain)) * longint'($signed(it.sample));
			h = clip((wide + 64'sd16384) >>> 15, H_LO, H_HI);
			hidden[addr] = h[H_W-1:0];
			term = (longint'($signed(it.output_gain)) * h + 64'sd8192) >>> 14;
			run_sum = clip(((it.state_index == '0) ? 64'sd0 : run_sum) + term, SUM_LO, SUM_HI);
			if (it.last_state) begin
				y = clip(run_sum, Y_LO, Y_HI);
				sums_due.push_back({y[Y_W-1:0], it.channel});
				run_sum = 0;
			end
		endfunction

		// Compare one output transaction with the oldest predicted sum
		function void check_result(logic [OUT_DATA_W-1:0] d);
			logic [45:0] want;
			sums_seen++;
			if (sums_due.size() == 0) begin
				$error("unexpected output transaction: channel %0d value %0d",
					d[5:0], $signed(d[45:6]));
				errors++;
				return;
			end
			want = sums_due.pop_front();
			if (d[5:0] !== want[5:0]) begin
				$error("out_channel mismatch: expected %0d, actual %0d", want[5:0], d[5:0]);
				errors++;
			end
			if (d[45:6] !== want[45:6]) begin
				$error("out_value mismatch: expected %0d, actual %0d",
					$signed(want[45:6]), $signed(d[45:6]));
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	scan_scoreboard sb;
	int  send_idle = 0;
	int  recv_idle = 0;
	int  items_sent = 0;
	int  stall_cycles = 0;
	bit  touched [1024];

	selective_state_space_scan dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Randomly withhold ready on the master side
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Observe both sides and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input({s_axis_tlast, s_axis_tuser, s_axis_tdata[73:0]});
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Drive one item after a random gap and hold it until accepted
	task automatic send_item(scan_item_t it);
		logic [CH_W+IDX_W-1:0] addr;
		addr = {it.channel, it.state_index};
		// a never-written entry must not be read back
		if (!touched[addr])
			it.first_step = 1'b1;
		touched[addr] = 1'b1;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, it[73:0]};
		s_axis_tuser <= it.first_step;
		s_axis_tlast <= it.last_state;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_fields(int ch, int n, int a, int b, int c, int x, bit f, bit l);
		scan_item_t it;
		it.channel = CH_W'(ch);
		it.state_index = IDX_W'(n);
		it.decay = COEF_W'(a);
		it.input_gain = COEF_W'(b);
		it.output_gain = COEF_W'(c);
		it.sample = COEF_W'(x);
		it.first_step = f;
		it.last_state = l;
		send_item(it);
	endtask

	// Hold off the sender until every predicted sum has come out
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_decay();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom_range(65535, 32769));
			3, 4, 5: return 16'($urandom_range(32768, 30000));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	// Extremes, rounding ties and the run-start and after-emit cases
	task automatic directed_items();
		send_fields(0, 0, 0, 32767, 32767, 32767, 1, 0);
		send_fields(0, 1, 0, -32768, -32768, -32768, 1, 0);
		send_fields(0, 2, 0, -32768, 32767, 32767, 1, 1);
		send_fields(0, 0, 32768, 100, -200, 300, 0, 0);
		send_fields(0, 1, 65535, 32767, 32767, 32767, 0, 1);
		// single item run that does not start at element zero
		send_fields(63, 15, 65535, 32767, 32767, 32767, 1, 1);
		send_fields(63, 15, 0, 0, -32768, 0, 0, 1);
		// run restarted at element zero discards the partial sum
		send_fields(5, 3, 32768, 20000, 20000, 20000, 1, 0);
		send_fields(5, 0, 32768, -20000, 20000, 20000, 1, 1);
		// rounding ties on h and on the output term
		send_fields(9, 4, 0, 1, 8192, 8192, 1, 0);
		send_fields(9, 5, 0, -1, 8192, 8192, 1, 1);
		send_fields(9, 6, 0, 1, 8192, 1, 1, 1);
		send_fields(9, 7, 0, 1, -8192, 1, 1, 1);
		send_fields(9, 6, 65535, 0, 1, 0, 0, 1);
		drain_outputs();
	endtask

	// Pump one entry into h saturation and keep adding until y saturates
	task automatic saturation_burst(int c);
		int ch;
		int n;
		ch = $urandom_range(63);
		n = $urandom_range(15, 1);
		for (int k = 0; k < 170; k++)
			send_fields(ch, n, 65535, 32767, c, 32767, k == 0, k == 169);
	endtask

	// Mostly well-formed runs with random content, the rest noise
	task automatic random_traffic(int count);
		scan_item_t it;
		int  done;
		int  start;
		int  len;
		bit  fresh;
		bit  closes;
		bit  drained;
		done = 0;
		drained = 0;
		while (done < count) begin
			if (!drained && done >= count / 2) begin
				drain_outputs();
				drained = 1;
			end
			if ($urandom_range(99) < 75) begin
				it.channel = CH_W'($urandom_range(63));
				start = ($urandom_range(99) < 80) ? 0 : $urandom_range(15);
				len = $urandom_range(16 - start, 1);
				fresh = ($urandom_range(99) < 20);
				closes = ($urandom_range(99) < 90);
				for (int k = 0; k < len; k++) begin
					it.state_index = IDX_W'(start + k);
					it.decay = pick_decay();
					it.input_gain = pick_coef();
					it.output_gain = pick_coef();
					it.sample = pick_coef();
					it.first_step = fresh;
					it.last_state = closes && (k == len - 1);
					send_item(it);
				end
				done += len;
			end else begin
				it = 76'({$urandom, $urandom, $urandom});
				send_item(it);
				done++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		send_idle = 37;
		recv_idle = 86;
		random_traffic(160);
		send_idle = 86;
		recv_idle = 37;
		random_traffic(160);
		send_idle = 0;
		recv_idle = 0;
		saturation_burst(32767);
		saturation_burst(-32768);
		random_traffic(160);
		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d input items and %0d channel sums under three idle patterns,",
			items_sent, sb.sums_seen);
		$display("with rounding ties, decay above one and saturation of h and y.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
